// ===== src/lssfe_pkg.sv =====
// Shared constants, types and the colour nibble encoder for the LED strip frame encoder.
`default_nettype none
package lssfe_pkg;

  localparam int MAX_LEDS    = 256;
  localparam int RESET_WORDS = 8;
  localparam int CFG_W       = 9;
  localparam int LED_W       = $clog2(MAX_LEDS);
  localparam int LEN_W       = $clog2(MAX_LEDS + 1);
  localparam int TAIL_W      = $clog2(RESET_WORDS + 1);
  localparam int COLOUR_W    = 24;

  localparam logic [3:0] ONE_NIBBLE  = 4'hE;
  localparam logic [3:0] ZERO_NIBBLE = 4'h8;

  localparam logic REQ_SET_PIXEL = 1'b0;
  localparam logic REQ_PULL      = 1'b1;

  typedef enum logic [1:0] {
    PART_GREEN = 2'd0,
    PART_RED   = 2'd1,
    PART_BLUE  = 2'd2
  } colour_part_t;

  // what travels with a pull while its pixel read is outstanding
  typedef struct packed {
    logic         colour;
    logic         written;
    colour_part_t part;
    logic         last;
  } pull_ctl_t;

  // colour bit n lands in word bits 4n+3..4n
  function automatic logic [31:0] encode_colour(input logic [7:0] level);
    logic [31:0] word;
    word = '0;
    for (int b = 0; b < 8; b++) begin
      word[b*4 +: 4] = level[b] ? ONE_NIBBLE : ZERO_NIBBLE;
    end
    return word;
  endfunction

endpackage
`default_nettype wire

// ===== src/lssfe_pixel_ram.sv =====
// Pixel colour memory: one write port, one read port with registered read data.
`default_nettype none
module lssfe_pixel_ram
  import lssfe_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [LED_W-1:0]    waddr,
  input  wire logic [COLOUR_W-1:0] wdata,
  input  wire logic                re,
  input  wire logic [LED_W-1:0]    raddr,
  output logic      [COLOUR_W-1:0] rdata
);

  logic [COLOUR_W-1:0] mem [MAX_LEDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/lssfe_word_out.sv =====
// Read-return stage and output register: picks the colour byte, encodes it, holds the word.
`default_nettype none
module lssfe_word_out
  import lssfe_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire pull_ctl_t           ctl,
  input  wire logic [COLOUR_W-1:0] rd_data,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic      [31:0]         spi_word,
  output logic                     last_of_frame,
  output logic                     can_take
);

  logic       s1_valid;
  pull_ctl_t  s1_ctl;
  logic       s1_adv;
  logic [7:0] level;
  logic [31:0] word_next;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign can_take = !s1_valid || !out_valid || !out_stall;

  always_comb begin
    case (s1_ctl.part)
      PART_GREEN: level = rd_data[23:16];
      PART_RED:   level = rd_data[15:8];
      default:    level = rd_data[7:0];
    endcase
    word_next = (s1_ctl.colour && s1_ctl.written) ? encode_colour(level) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctl <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      spi_word      <= word_next;
      last_of_frame <= s1_ctl.last;
    end
  end

endmodule
`default_nettype wire

// ===== src/led_strip_spi_frame_encoder.sv =====
// Top level of the LED strip SPI frame encoder: pixel store, frame sequencer, output stage.
//
// Input channel (in_valid / in_stall): one word per request. req_type selects a
// set-pixel request (led_index, red, green, blue) or a pull of the next frame word.
// Set-pixel words give no output; an index at or beyond the strip length is dropped.
// Output channel (out_valid / out_stall): spi_word and last_of_frame, one per pull.
// A frame is one zero word, green/red/blue per LED, then eight zero words; the
// final zero word carries last_of_frame and the next pull starts a new frame.
// Config channel (cfg_valid / cfg_ready): writes the strip length on cfg_length
// (clamped to 256) and restarts the frame; cfg_ready is always high, write it only
// while idle.
// Path: the pixel memory is read when a pull is taken, together with the pull's control
// bits; the encoded word is then registered in the output register when that is free.
// Throughput: one word per cycle while the output is not stalled, set by the single pixel memory read port.
// Reset clears the length, the frame position and every written flag; a never
// written LED sends zero words. When out_stall is held, one pull waits behind the
// output word and in_stall rises until the output word is taken.
`default_nettype none
module led_strip_spi_frame_encoder
  import lssfe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // request words
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             req_type,
  input  wire logic [7:0]       led_index,
  input  wire logic [7:0]       red,
  input  wire logic [7:0]       green,
  input  wire logic [7:0]       blue,
  // frame words
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [31:0]      spi_word,
  output logic                  last_of_frame,
  // configuration
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_length
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_COLOUR,
    PH_TAIL
  } phase_t;

  phase_t             phase;
  logic [CFG_W-1:0]   length_q;
  logic [LED_W-1:0]   led_cnt;
  colour_part_t       part;
  logic [TAIL_W-1:0]  tail_cnt;
  logic [MAX_LEDS-1:0] written;

  logic [LEN_W-1:0]   leds;
  logic               can_take;
  logic               in_acc;
  logic               pull_acc;
  logic               set_acc;
  logic               ram_we;
  logic               cfg_wr;
  logic               last_led;
  logic               tail_end;
  pull_ctl_t          ctl;
  logic [COLOUR_W-1:0] rd_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // effective LED count: lengths above the store depth clamp to it
  assign leds = (32'(length_q) > MAX_LEDS) ? LEN_W'(MAX_LEDS) : LEN_W'(length_q);

  assign in_stall = !can_take;
  assign in_acc   = in_valid && !in_stall;
  assign pull_acc = in_acc && (req_type == REQ_PULL);
  assign set_acc  = in_acc && (req_type == REQ_SET_PIXEL);
  assign ram_we   = set_acc && (32'(led_index) < 32'(leds));

  assign last_led = (LEN_W'(led_cnt) + LEN_W'(1)) == leds;
  assign tail_end = tail_cnt == TAIL_W'(RESET_WORDS - 1);

  always_comb begin
    ctl.colour  = phase == PH_COLOUR;
    ctl.written = written[led_cnt];
    ctl.part    = part;
    ctl.last    = (phase == PH_TAIL) && tail_end;
  end

  // frame sequencer; a length write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LEAD;
      length_q <= '0;
      led_cnt  <= '0;
      part     <= PART_GREEN;
      tail_cnt <= '0;
    end else if (cfg_wr) begin
      phase    <= PH_LEAD;
      length_q <= cfg_length;
    end else if (pull_acc) begin
      unique case (phase)
        PH_LEAD: begin
          led_cnt  <= '0;
          part     <= PART_GREEN;
          tail_cnt <= '0;
          phase    <= (leds == '0) ? PH_TAIL : PH_COLOUR;
        end
        PH_COLOUR: begin
          unique case (part)
            PART_GREEN: part <= PART_RED;
            PART_RED:   part <= PART_BLUE;
            default: begin
              part <= PART_GREEN;
              if (last_led) begin
                phase <= PH_TAIL;
              end else begin
                led_cnt <= led_cnt + LED_W'(1);
              end
            end
          endcase
        end
        PH_TAIL: begin
          if (tail_end) begin
            phase <= PH_LEAD;
          end else begin
            tail_cnt <= tail_cnt + TAIL_W'(1);
          end
        end
        default: phase <= PH_LEAD;
      endcase
    end
  end

  // written flags, one per LED, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ram_we) begin
      written[LED_W'(led_index)] <= 1'b1;
    end
  end

  lssfe_pixel_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (LED_W'(led_index)),
    .wdata ({green, red, blue}),
    .re    (pull_acc),
    .raddr (led_cnt),
    .rdata (rd_data)
  );

  lssfe_word_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (pull_acc),
    .ctl           (ctl),
    .rd_data       (rd_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .spi_word      (spi_word),
    .last_of_frame (last_of_frame),
    .can_take      (can_take)
  );

  a_led_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_COLOUR) |-> (32'(led_cnt) < 32'(leds)))
    else $error("colour phase LED counter beyond strip length");

  a_tail_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TAIL) |-> (32'(tail_cnt) < RESET_WORDS))
    else $error("tail counter beyond reset word count");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (phase == PH_LEAD))
    else $error("length write did not restart the frame");

  a_last_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_frame) |-> (spi_word == '0))
    else $error("frame end word is not a zero word");

endmodule
`default_nettype wire

// ===== test/led_strip_spi_frame_encoder_tb.sv =====
// Self-checking testbench for the LED strip SPI frame encoder: directed table, then random phases.
`timescale 1ns / 100ps
module led_strip_spi_frame_encoder_tb;
  import lssfe_pkg::*;

  // ---------------------------------------------------------------- types
  // one request word as queued for the sender
  typedef struct {
    logic        kind;
    logic [7:0]  idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    bit          fixed;       // directed row: expectation typed in the table
    logic [31:0] fixed_word;
    logic        fixed_last;
  } pixel_req_t;

  // one frame word as the block should return it
  typedef struct {
    logic [31:0] word;
    logic        last;
  } frame_word_t;

  typedef enum logic {
    ROW_REQ,
    ROW_LEN
  } row_kind_t;

  // directed table row: either a request word or a strip length write
  typedef struct packed {
    row_kind_t        kind;
    logic             req;
    logic [CFG_W-1:0] len;
    logic [7:0]       idx;
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic [31:0]      word;
    logic             last;
  } dir_row_t;

  localparam int DIR_ROWS    = 26;
  localparam int ITEM_TARGET = 1550;
  localparam int DRAIN_GAP   = 4;    // settle time; the output register sits behind the read-return stage

  // ---------------------------------------------------------------- signals
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             req_type = REQ_PULL;
  logic [7:0]       led_index = '0;
  logic [7:0]       red = '0;
  logic [7:0]       green = '0;
  logic [7:0]       blue = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [31:0]      spi_word;
  logic             last_of_frame;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_length = '0;

  led_strip_spi_frame_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .led_index     (led_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .spi_word      (spi_word),
    .last_of_frame (last_of_frame),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_length    (cfg_length)
  );

  // ---------------------------------------------------------------- bookkeeping
  pixel_req_t  req_backlog[$];     // waiting for the sender
  frame_word_t frame_words_due[$]; // expected output words, oldest first
  pixel_req_t  cur_req;            // word currently presented on the input
  int          reqs_queued = 0;
  int          reqs_taken  = 0;
  int          fail_count  = 0;
  bit          calm = 1'b0;        // no idling on either side while set

  // own copy of the block's state
  logic [24:0]      led_colours [MAX_LEDS]; // bit 24 = written, then G, R, B
  int               frame_pos;
  logic [CFG_W-1:0] model_len;

  dir_row_t dir_rows [DIR_ROWS];

  // ---------------------------------------------------------------- clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  // each colour bit becomes one nibble, MSB of the colour in word bits 31..28
  function automatic logic [31:0] spi_nibbles(input logic [7:0] level);
    logic [31:0] w = '0;
    for (int n = 7; n >= 0; n--) begin
      w = {w[27:0], level[n] ? ONE_NIBBLE : ZERO_NIBBLE};
    end
    return w;
  endfunction

  // applies one accepted request word; a pull queues the word it should return
  function automatic void apply_request(input pixel_req_t q);
    int           leds;
    int           colour_words;
    int           frame_len;
    int           pos;
    int           k;
    logic [24:0]  entry;
    colour_part_t part;
    frame_word_t  e;
    leds = (model_len > MAX_LEDS) ? MAX_LEDS : int'(model_len);
    reqs_taken++;
    if (q.kind == REQ_SET_PIXEL) begin
      // indices beyond the strip are simply dropped
      if (int'(q.idx) < leds) begin
        led_colours[q.idx] = {1'b1, q.g, q.r, q.b};
      end
      return;
    end
    colour_words = leds * 3;
    frame_len    = 1 + colour_words + RESET_WORDS;
    pos          = (frame_pos >= frame_len) ? 0 : frame_pos;
    e.word       = '0;
    e.last       = 1'b0;
    if (pos >= 1 && pos <= colour_words) begin
      k     = pos - 1;
      entry = led_colours[k / 3];
      part  = colour_part_t'(k % 3);
      if (entry[24]) begin
        case (part)
          PART_GREEN: e.word = spi_nibbles(entry[23:16]);
          PART_RED:   e.word = spi_nibbles(entry[15:8]);
          default:    e.word = spi_nibbles(entry[7:0]);
        endcase
      end
    end
    if (pos == frame_len - 1) begin
      e.last    = 1'b1;
      frame_pos = 0;
    end else begin
      frame_pos = pos + 1;
    end
    if (q.fixed) begin
      e.word = q.fixed_word;
      e.last = q.fixed_last;
    end
    frame_words_due.push_back(e);
  endfunction

  // ---------------------------------------------------------------- sender
  // holds the word until taken; otherwise picks the next one or idles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(cur_req);
      end
      if (!in_valid || !in_stall) begin
        if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          cur_req   = req_backlog.pop_front();
          in_valid  <= 1'b1;
          req_type  <= cur_req.kind;
          led_index <= cur_req.idx;
          red       <= cur_req.r;
          green     <= cur_req.g;
          blue      <= cur_req.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_words_due.size() == 0) begin
          $error("unexpected output word: spi_word %h last_of_frame %b",
                 spi_word, last_of_frame);
          fail_count++;
        end else begin
          automatic frame_word_t e = frame_words_due.pop_front();
          if (spi_word !== e.word) begin
            $error("spi_word: expected %h, got %h", e.word, spi_word);
            fail_count++;
          end
          if (last_of_frame !== e.last) begin
            $error("last_of_frame: expected %b, got %b", e.last, last_of_frame);
            fail_count++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 33);
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  function automatic dir_row_t pull_row(input logic [31:0] word, input logic last);
    dir_row_t row = '0;
    row.kind = ROW_REQ;
    row.req  = REQ_PULL;
    row.word = word;
    row.last = last;
    return row;
  endfunction

  function automatic dir_row_t set_row(input logic [7:0] idx, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b);
    dir_row_t row = '0;
    row.kind = ROW_REQ;
    row.req  = REQ_SET_PIXEL;
    row.idx  = idx;
    row.r    = r;
    row.g    = g;
    row.b    = b;
    return row;
  endfunction

  function automatic dir_row_t len_row(input logic [CFG_W-1:0] len);
    dir_row_t row = '0;
    row.kind = ROW_LEN;
    row.len  = len;
    return row;
  endfunction

  function automatic void queue_req(input pixel_req_t q);
    req_backlog.push_back(q);
    reqs_queued++;
  endfunction

  // sender pauses here until every word sent has been answered
  task automatic wait_drained();
    while (reqs_taken != reqs_queued || frame_words_due.size() != 0) begin
      @(posedge clk);
    end
    // a trailing set-pixel word gives no output, so leave the pipe time to empty
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // length writes only when idle; each one restarts the frame
  task automatic write_length(input logic [CFG_W-1:0] len);
    wait_drained();
    @(posedge clk);
    cfg_valid  <= 1'b1;
    cfg_length <= len;
    do @(posedge clk); while (!cfg_ready);
    model_len = len;
    frame_pos = 0;
    cfg_valid <= 1'b0;
  endtask

  // new length, then mostly pulls with set-pixel words mixed in
  task automatic run_phase(input logic [CFG_W-1:0] len, input int pulls);
    pixel_req_t q;
    int         leds;
    leds = (len > MAX_LEDS) ? MAX_LEDS : int'(len);
    write_length(len);
    while (pulls > 0) begin
      q.fixed = 1'b0;
      q.r     = 8'($urandom);
      q.g     = 8'($urandom);
      q.b     = 8'($urandom);
      if ($urandom_range(99) < 22) begin
        q.kind = REQ_SET_PIXEL;
        // mostly in range, some beyond the end of the strip
        if (leds > 0 && $urandom_range(99) < 80) begin
          q.idx = 8'($urandom_range(leds - 1));
        end else begin
          q.idx = 8'($urandom_range(255));
        end
      end else begin
        q.kind = REQ_PULL;
        q.idx  = 8'($urandom);
        pulls--;
      end
      queue_req(q);
    end
  endtask

  // ---------------------------------------------------------------- main sequence
  initial begin
    pixel_req_t q;
    int         len;
    int         leds;
    int         flen;
    int         pulls;

    foreach (led_colours[i]) led_colours[i] = '0;
    frame_pos = 0;
    model_len = '0;

    dir_rows = '{
      // empty strip straight after reset: nine zero words, last one flagged
      pull_row(32'h0, 1'b0), pull_row(32'h0, 1'b0), pull_row(32'h0, 1'b0),
      pull_row(32'h0, 1'b0), pull_row(32'h0, 1'b0), pull_row(32'h0, 1'b0),
      pull_row(32'h0, 1'b0), pull_row(32'h0, 1'b0), pull_row(32'h0, 1'b1),
      // dropped: no LEDs in use yet
      set_row(8'd0, 8'hFF, 8'hFF, 8'hFF),
      len_row(9'd2),
      set_row(8'd1, 8'h00, 8'hFF, 8'h01),
      set_row(8'd255, 8'hFF, 8'hFF, 8'hFF),   // beyond the strip, dropped
      pull_row(32'h0, 1'b0),                  // leading zero word
      // LED 0 never written: three zero words
      pull_row(32'h0, 1'b0), pull_row(32'h0, 1'b0), pull_row(32'h0, 1'b0),
      pull_row(32'hEEEEEEEE, 1'b0),           // LED 1 green
      pull_row(32'h88888888, 1'b0),           // red
      pull_row(32'h8888888E, 1'b0),           // blue, LSB in the low nibble
      // oversized length clamps; the write restarts the frame mid-way
      len_row(9'd511),
      set_row(8'd0, 8'h80, 8'h00, 8'hFF),
      pull_row(32'h0, 1'b0),
      pull_row(32'h88888888, 1'b0),
      pull_row(32'hE8888888, 1'b0),           // MSB in the top nibble
      pull_row(32'hEEEEEEEE, 1'b0)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LEN) begin
        write_length(dir_rows[i].len);
      end else begin
        q.kind       = dir_rows[i].req;
        q.idx        = dir_rows[i].idx;
        q.r          = dir_rows[i].r;
        q.g          = dir_rows[i].g;
        q.b          = dir_rows[i].b;
        q.fixed      = (dir_rows[i].req == REQ_PULL);
        q.fixed_word = dir_rows[i].word;
        q.fixed_last = dir_rows[i].last;
        queue_req(q);
      end
    end

    // full frame at the largest strip, running into the next one
    run_phase(9'd256, 1 + 3 * MAX_LEDS + RESET_WORDS + 3);
    // clamped lengths, cut off mid-frame; first of them with no idling at all
    calm = 1'b1;
    run_phase(9'd300, 60);
    wait_drained();
    calm = 1'b0;
    run_phase(9'd511, 40);
    run_phase(9'd0, 20);

    // mostly short strips so frames wrap often; old colours come back as lengths grow
    while (reqs_queued < ITEM_TARGET) begin
      len   = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      leds  = len;
      flen  = 1 + 3 * leds + RESET_WORDS;
      pulls = flen * int'($urandom_range(1, 2)) + int'($urandom_range(flen - 1));
      // keep the total close to the target
      if (pulls > ITEM_TARGET - reqs_queued) begin
        pulls = ITEM_TARGET - reqs_queued;
      end
      run_phase(CFG_W'(len), pulls);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
